### rtl/fgti_pkg.sv
// ----------------------------------------------------------------------------
// fgti_pkg
// Shared types and constants of the field grid trilinear interpolation unit.
// ----------------------------------------------------------------------------
package fgti_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_X_ORIGIN   = 3'd0,
    REG_Y_ORIGIN   = 3'd1,
    REG_Z_ORIGIN   = 3'd2,
    REG_X_INV_SP   = 3'd3,
    REG_Y_INV_SP   = 3'd4,
    REG_Z_INV_SP   = 3'd5,
    REG_MIRROR_Z   = 3'd6,
    REG_FIELD_GAIN = 3'd7
  } cfg_reg_e;

  // opcodes of an input transaction
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // fixed-point formats
  localparam int GAIN_FRAC  = 24;
  localparam int PROD_FRAC  = 40;
  localparam int FRAC_LIMIT = 1 << 30;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // reset values of the registers
  localparam logic [31:0] INV_SP_RESET = 32'h0001_0000;
  localparam logic [31:0] GAIN_RESET   = 32'h0100_0000;

  // per-query side information that travels with the interpolation pipe
  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic [2:0]         par;
    logic               flip;
  } side_t;

endpackage

### rtl/fgti_ram.sv
// ----------------------------------------------------------------------------
// fgti_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module fgti_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/field_grid_trilinear_interp_unit.sv
// ----------------------------------------------------------------------------
// field_grid_trilinear_interp_unit
// Bx/By/Bz tables on a uniform 3D grid, loaded entry by entry, with scaled
// trilinear interpolation at query points.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  config    cfg_we_i cfg_idx_i cfg_wdata_i               write on cfg_we_i
//  input     opcode_i load_* query_*                      start_i && !busy_o
//  result    field_x_o field_y_o field_z_o                done_o, one cycle
//
//  One transaction is taken every cycle; busy_o stays low.
//  A query's result passes the locate pipe, the bank read, three lerp levels
//  and the gain, in that order, before done_o marks it.
//  Tables sit in eight parity banks, so all eight corners read in the same cycle.
//  Loads write the banks at the same pipe stage where queries read them.
//  Reset clears control and configuration; table contents are not cleared.
// ----------------------------------------------------------------------------
module field_grid_trilinear_interp_unit #(
  parameter int GRID_NX   = 32,
  parameter int GRID_NY   = 32,
  parameter int GRID_NZ   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               opcode_i,
  input  logic [4:0]         load_ix_i,
  input  logic [4:0]         load_iy_i,
  input  logic [5:0]         load_iz_i,
  input  logic signed [31:0] load_bx_i,
  input  logic signed [31:0] load_by_i,
  input  logic signed [31:0] load_bz_i,
  input  logic signed [31:0] query_x_i,
  input  logic signed [31:0] query_y_i,
  input  logic signed [31:0] query_z_i,
  output logic               done_o,
  output logic signed [31:0] field_x_o,
  output logic signed [31:0] field_y_o,
  output logic signed [31:0] field_z_o
);

  localparam int SH    = fgti_pkg::PROD_FRAC - FRAC_BITS;
  localparam int UW    = 66 - SH;
  localparam int NMXY  = (GRID_NX > GRID_NY) ? GRID_NX : GRID_NY;
  localparam int NMAX  = (NMXY > GRID_NZ) ? NMXY : GRID_NZ;
  localparam int CW    = $clog2(NMAX);
  localparam int CW1   = CW + 1;
  localparam int HXW   = (GRID_NX > 2) ? $clog2((GRID_NX + 1) / 2) : 1;
  localparam int HYW   = (GRID_NY > 2) ? $clog2((GRID_NY + 1) / 2) : 1;
  localparam int HZW   = (GRID_NZ > 2) ? $clog2((GRID_NZ + 1) / 2) : 1;
  localparam int AW    = HXW + HYW + HZW;
  localparam int DEPTH = 1 << AW;
  localparam logic [64:0] RND = (65'd1 << SH) - 65'd1;
  localparam logic signed [UW-1:0] FLIM_P = UW'(fgti_pkg::FRAC_LIMIT);
  localparam logic signed [UW-1:0] FLIM_N = -FLIM_P;

  typedef struct packed {
    logic          ok;
    logic [2:0]    bank;
    logic [AW-1:0] addr;
    logic [95:0]   data;
  } ld_t;

  function automatic int axis_n(input int a);
    int n;
    case (a)
      0:       n = GRID_NX;
      1:       n = GRID_NY;
      default: n = GRID_NZ;
    endcase
    return n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = fgti_pkg::S32_MAX;
    end else if (v < -66'sd2147483648) begin
      r = fgti_pkg::S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return 33'(b) - 33'(a);
  endfunction

  function automatic logic signed [31:0] lerp_fin(input logic signed [31:0] a,
                                                  input logic signed [64:0] p);
    return sat32(66'(a) + 66'(p >>> FRAC_BITS));
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] org_q [3];
  logic [31:0]        inv_q [3];
  logic               mirror_q;
  logic signed [31:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        org_q[a] <= '0;
        inv_q[a] <= fgti_pkg::INV_SP_RESET;
      end
      mirror_q <= 1'b0;
      gain_q   <= fgti_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (fgti_pkg::cfg_reg_e'(cfg_idx_i))
        fgti_pkg::REG_X_ORIGIN:   org_q[0] <= cfg_wdata_i;
        fgti_pkg::REG_Y_ORIGIN:   org_q[1] <= cfg_wdata_i;
        fgti_pkg::REG_Z_ORIGIN:   org_q[2] <= cfg_wdata_i;
        fgti_pkg::REG_X_INV_SP:   inv_q[0] <= cfg_wdata_i;
        fgti_pkg::REG_Y_INV_SP:   inv_q[1] <= cfg_wdata_i;
        fgti_pkg::REG_Z_INV_SP:   inv_q[2] <= cfg_wdata_i;
        fgti_pkg::REG_MIRROR_Z:   mirror_q <= cfg_wdata_i[0];
        fgti_pkg::REG_FIELD_GAIN: gain_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // accept
  // --------------------------------------------------------------------------
  logic acc;
  assign busy_o = 1'b0;
  assign acc    = start_i & ~busy_o;

  // front pipe control: stages 1..5
  logic [4:0] fv_q, fv_d;
  logic [4:0] fq_q, fq_d;
  ld_t        ld_q [5];
  ld_t        ld_d;
  logic [3:0] flp_q;

  // stage 1: offsets from the origin, load entry decode
  logic signed [31:0] qc [3];
  logic signed [32:0] d1_q [3], d1_d [3];
  logic [7:0]         lhx, lhy, lhz;

  assign qc[0] = query_x_i;
  assign qc[1] = query_y_i;
  assign qc[2] = query_z_i;
  assign lhx   = 8'(load_ix_i >> 1);
  assign lhy   = 8'(load_iy_i >> 1);
  assign lhz   = 8'(load_iz_i >> 1);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d1_d[a] = 33'(qc[a]) - 33'(org_q[a]);
    end
    ld_d.ok   = (opcode_i == fgti_pkg::OP_LOAD) && (9'(load_ix_i) < 9'(GRID_NX)) &&
                (9'(load_iy_i) < 9'(GRID_NY)) && (9'(load_iz_i) < 9'(GRID_NZ));
    ld_d.bank = {load_ix_i[0], load_iy_i[0], load_iz_i[0]};
    ld_d.addr = {lhx[HXW-1:0], lhy[HYW-1:0], lhz[HZW-1:0]};
    ld_d.data = {load_bz_i, load_by_i, load_bx_i};
    fv_d      = {fv_q[3:0], acc};
    fq_d      = {fq_q[3:0], opcode_i == fgti_pkg::OP_QUERY};
  end

  // stage 2: magnitude and sign, z mirroring
  logic [31:0] mag_q [3], mag_d [3];
  logic        neg2_q [3], neg2_d [3];
  logic        flip_d;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      neg2_d[a] = d1_q[a][32];
      mag_d[a]  = d1_q[a][32] ? 32'(-d1_q[a]) : d1_q[a][31:0];
    end
    flip_d = mirror_q & d1_q[2][32];
    if (mirror_q) begin
      neg2_d[2] = 1'b0;
    end
  end

  // stage 3: scaling by the inverse spacing
  logic [63:0] prod_q [3], prod_d [3];
  logic        neg3_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_d[a] = 64'(mag_q[a]) * 64'(inv_q[a]);
    end
  end

  // stage 4: cell coordinate, rounded toward minus infinity
  logic signed [UW-1:0] u_q [3], u_d [3];

  always_comb begin
    logic [64:0]   rs;
    logic [64:0]   rsh;
    logic [UW-1:0] umag;
    for (int a = 0; a < 3; a++) begin
      rs      = {1'b0, prod_q[a]} + (neg3_q[a] ? RND : 65'd0);
      rsh     = rs >> SH;
      umag    = rsh[UW-1:0];
      u_d[a]  = neg3_q[a] ? -umag : umag;
    end
  end

  // stage 5: cell index clamp and fraction limit
  logic [CW-1:0]      cell_q [3], cell_d [3];
  logic signed [31:0] frac_q [3], frac_d [3];

  always_comb begin
    logic signed [UW-1:0] cint;
    logic signed [UW-1:0] clw;
    logic signed [UW-1:0] fw;
    logic signed [UW-1:0] cmax;
    for (int a = 0; a < 3; a++) begin
      cmax = $signed(UW'(axis_n(a) - 2));
      cint = u_q[a] >>> FRAC_BITS;
      if (cint < 0) begin
        clw = '0;
      end else if (cint > cmax) begin
        clw = cmax;
      end else begin
        clw = cint;
      end
      fw = u_q[a] - (clw <<< FRAC_BITS);
      if (fw > FLIM_P) begin
        fw = FLIM_P;
      end else if (fw < FLIM_N) begin
        fw = FLIM_N;
      end
      cell_d[a] = clw[CW-1:0];
      frac_d[a] = fw[31:0];
    end
  end

  // front pipe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      fq_q <= '0;
    end else begin
      fv_q <= fv_d;
      fq_q <= fq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_q[0] <= ld_d;
    for (int s = 1; s < 5; s++) begin
      ld_q[s] <= ld_q[s-1];
    end
    flp_q <= {flp_q[2:0], flip_d};
    for (int a = 0; a < 3; a++) begin
      d1_q[a]   <= d1_d[a];
      mag_q[a]  <= mag_d[a];
      neg2_q[a] <= neg2_d[a];
      prod_q[a] <= prod_d[a];
      neg3_q[a] <= neg2_q[a];
      u_q[a]    <= u_d[a];
      cell_q[a] <= cell_d[a];
      frac_q[a] <= frac_d[a];
    end
  end

  // --------------------------------------------------------------------------
  // parity banks: a load writes, a query reads all eight corners
  // --------------------------------------------------------------------------
  logic [CW:0]    hq [3][2];
  logic [AW-1:0]  bank_addr [8];
  logic           bank_we [8];
  logic [95:0]    rd [8];
  logic           mem_ld, mem_qry;

  assign mem_ld  = fv_q[4] & ~fq_q[4] & ld_q[4].ok;
  assign mem_qry = fv_q[4] & fq_q[4];

  always_comb begin
    logic [AW-1:0] qa;
    for (int a = 0; a < 3; a++) begin
      for (int p = 0; p < 2; p++) begin
        hq[a][p] = ({1'b0, cell_q[a]} + CW1'(p ^ cell_q[a][0])) >> 1;
      end
    end
    for (int b = 0; b < 8; b++) begin
      qa = {hq[0][(b >> 2) & 1][HXW-1:0], hq[1][(b >> 1) & 1][HYW-1:0],
            hq[2][b & 1][HZW-1:0]};
      bank_addr[b] = mem_qry ? qa : ld_q[4].addr;
      bank_we[b]   = mem_ld && (ld_q[4].bank == 3'(b));
    end
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    fgti_ram #(
      .WIDTH(96),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .addr_i  (bank_addr[b]),
      .wdata_i (ld_q[4].data),
      .rdata_o (rd[b])
    );
  end

  // --------------------------------------------------------------------------
  // back pipe: stages 6..18
  // --------------------------------------------------------------------------
  logic [12:0]     vq_q;
  fgti_pkg::side_t side_q [10];
  fgti_pkg::side_t side_d;

  always_comb begin
    side_d.fx   = frac_q[0];
    side_d.fy   = frac_q[1];
    side_d.fz   = frac_q[2];
    side_d.par  = {cell_q[0][0], cell_q[1][0], cell_q[2][0]};
    side_d.flip = flp_q[3];
  end

  // corner routing from the banks, ordered component, x, y, z
  logic signed [31:0] cv [24];

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      for (int k = 0; k < 8; k++) begin
        cv[m*8 + k] = rd[3'(k) ^ side_q[0].par][m*32 +: 32];
      end
    end
  end

  // z level: 12 lanes
  logic signed [31:0] za_q [12], zb_q [12], zl_q [12];
  logic signed [32:0] zd_q [12];
  logic signed [64:0] zp_q [12];

  // y level: 6 lanes
  logic signed [31:0] ya_q [6], yb_q [6], yl_q [6];
  logic signed [32:0] yd_q [6];
  logic signed [64:0] yp_q [6];

  // x level: 3 lanes
  logic signed [31:0] xa_q [3], xb_q [3], xl_q [3];
  logic signed [32:0] xd_q [3];
  logic signed [64:0] xp_q [3];

  // bz negation and gain
  logic signed [31:0] nf_q [3];
  logic signed [63:0] gp_q [3];
  logic signed [31:0] out_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= '0;
    end else begin
      vq_q <= {vq_q[11:0], mem_qry};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int s = 1; s < 10; s++) begin
      side_q[s] <= side_q[s-1];
    end
    // z lerp
    for (int j = 0; j < 12; j++) begin
      za_q[j] <= cv[2*j];
      zd_q[j] <= diff33(cv[2*j], cv[2*j + 1]);
      zb_q[j] <= za_q[j];
      zp_q[j] <= $signed(zd_q[j]) * $signed(side_q[1].fz);
      zl_q[j] <= lerp_fin(zb_q[j], zp_q[j]);
    end
    // y lerp
    for (int j = 0; j < 6; j++) begin
      ya_q[j] <= zl_q[2*j];
      yd_q[j] <= diff33(zl_q[2*j], zl_q[2*j + 1]);
      yb_q[j] <= ya_q[j];
      yp_q[j] <= $signed(yd_q[j]) * $signed(side_q[4].fy);
      yl_q[j] <= lerp_fin(yb_q[j], yp_q[j]);
    end
    // x lerp
    for (int j = 0; j < 3; j++) begin
      xa_q[j] <= yl_q[2*j];
      xd_q[j] <= diff33(yl_q[2*j], yl_q[2*j + 1]);
      xb_q[j] <= xa_q[j];
      xp_q[j] <= $signed(xd_q[j]) * $signed(side_q[7].fx);
      xl_q[j] <= lerp_fin(xb_q[j], xp_q[j]);
    end
    // mirrored bz negation, saturating
    nf_q[0] <= xl_q[0];
    nf_q[1] <= xl_q[1];
    if (!side_q[9].flip) begin
      nf_q[2] <= xl_q[2];
    end else if (xl_q[2] == fgti_pkg::S32_MIN) begin
      nf_q[2] <= fgti_pkg::S32_MAX;
    end else begin
      nf_q[2] <= -xl_q[2];
    end
    // gain
    for (int m = 0; m < 3; m++) begin
      gp_q[m]  <= $signed(nf_q[m]) * $signed(gain_q);
      out_q[m] <= sat32(66'(gp_q[m] >>> fgti_pkg::GAIN_FRAC));
    end
  end

  assign done_o    = vq_q[12];
  assign field_x_o = out_q[0];
  assign field_y_o = out_q[1];
  assign field_z_o = out_q[2];

endmodule
